// ===== rtl/core/tensor_reduction_engine_macros.svh =====
// Assertion macros shared by the tensor reduction engine RTL.
`ifndef TENSOR_REDUCTION_ENGINE_MACROS_SVH
`define TENSOR_REDUCTION_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising clock edge out of reset.
`define TRE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tensor_reduction_engine: same-cycle check failed");
// Next-cycle implication, checked on every rising clock edge out of reset.
`define TRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tensor_reduction_engine: next-cycle check failed");
`else
`define TRE_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define TRE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/tre_pkg.sv =====
// Types, mode codes and helpers for the tensor reduction engine.
`default_nettype none
package tre_pkg;

  localparam int unsigned VAL_W = 64;
  localparam int unsigned OFF_W = 32;
  localparam int unsigned MODE_W = 3;

  localparam logic [MODE_W-1:0] MODE_SUM     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SUM_ABS = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MAX     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MAX_ABS = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MIN     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MIN_ABS = 3'd5;
  localparam logic [MODE_W-1:0] MODE_NORM2   = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_FOLD,
    ST_ROOT,
    ST_EMIT
  } tre_state_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    logic                    sub;
  } alu_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sat;
    logic                    neg;
    logic                    zero;
  } alu_rsp_t;

  function automatic logic mode_is_cmp(input logic [MODE_W-1:0] m);
    return (m == MODE_MAX) || (m == MODE_MAX_ABS) || (m == MODE_MIN) || (m == MODE_MIN_ABS);
  endfunction

  function automatic logic mode_is_max(input logic [MODE_W-1:0] m);
    return (m == MODE_MAX) || (m == MODE_MAX_ABS);
  endfunction

  function automatic logic mode_uses_abs(input logic [MODE_W-1:0] m);
    return (m == MODE_SUM_ABS) || (m == MODE_MAX_ABS) || (m == MODE_MIN_ABS);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tre_alu.sv =====
// Shared 64-bit add/subtract unit with signed saturation and sign/zero flags.
`default_nettype none
module tre_alu (
  input  tre_pkg::alu_req_t req,
  output tre_pkg::alu_rsp_t rsp
);
  import tre_pkg::*;

  logic signed [VAL_W:0] a_ext;
  logic signed [VAL_W:0] b_ext;
  logic signed [VAL_W:0] full;

  assign a_ext = {req.a[VAL_W-1], req.a};
  assign b_ext = req.sub ? ~{req.b[VAL_W-1], req.b} : {req.b[VAL_W-1], req.b};
  assign full  = a_ext + b_ext + {{VAL_W{1'b0}}, req.sub};

  always_comb begin
    rsp.neg  = full[VAL_W];
    rsp.zero = (full == '0);
    // The 65-bit result overflows 64 bits when its two top bits differ.
    if (full[VAL_W] != full[VAL_W-1]) begin
      rsp.sat = full[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      rsp.sat = full[VAL_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tensor_reduction_engine.sv =====
// Top level of the tensor reduction engine: sequencer, state and output register.
//
//   Channel   Direction  Handshake            Payload
//   in_*      input      in_valid/in_ready    sample, element_offset, last_element
//   out_*     output     out_valid/out_ready  reduced_value, winner_offset
//   cfg_*     input      cfg_wr_en            op_mode (3 bits), no read-back
//
// Every element is folded by one shared 64-bit add/subtract unit. An element
// passes through transfer and fold; in norm2 mode it passes through transfer,
// square and fold. The last element of a norm2 tensor adds square-root
// iterations on the same unit, and the last element of any tensor adds a
// step to load the output register.
// Reset (rst_n low, synchronous) sets op_mode to sum and clears the running
// state. A result waiting on out_ready does not block the transfer of the
// next element; only a second result waits until the output register is free.
`default_nettype none
`include "tensor_reduction_engine_macros.svh"
module tensor_reduction_engine #(
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_sample,
  input  logic signed [31:0]  in_element_offset,
  input  logic                in_last_element,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [63:0]  out_reduced_value,
  output logic signed [31:0]  out_winner_offset,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_wr_data
);
  import tre_pkg::*;

  localparam logic [SAMPLE_BITS-1:0] SAMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] SAMP_LIM = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [VAL_W-1:0] ROOT_START = {2'b01, {(VAL_W-2){1'b0}}};

  tre_state_t state_r, state_nxt;

  logic [MODE_W-1:0]          op_mode_r;
  logic signed [SAMPLE_BITS-1:0] samp_r;
  logic [OFF_W-1:0]           off_r;
  logic                       last_r;
  logic signed [VAL_W-1:0]    operand_r;
  logic signed [VAL_W-1:0]    running_r;
  logic [OFF_W-1:0]           best_r;
  logic                       first_r;
  logic [VAL_W-1:0]           res_r;
  logic [VAL_W-1:0]           bit_r;
  logic                       out_valid_r;
  logic signed [VAL_W-1:0]    out_reduced_value_r;
  logic [OFF_W-1:0]           out_winner_offset_r;

  logic                       in_xfer;
  logic                       out_free;
  logic                       is_norm;
  logic                       win;
  logic signed [SAMPLE_BITS-1:0] in_samp;
  logic [SAMPLE_BITS-1:0]     in_abs;
  logic signed [2*SAMPLE_BITS-1:0] square;
  alu_req_t                   alu_req;
  alu_rsp_t                   alu_rsp;

  tre_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign is_norm  = (op_mode_r == MODE_NORM2);

  // Only the low SAMPLE_BITS bits of the sample count; the most negative
  // value has no positive twin, so its magnitude saturates.
  assign in_samp = in_sample[SAMPLE_BITS-1:0];
  assign in_abs  = !in_samp[SAMPLE_BITS-1] ? in_samp :
                   (in_samp == SAMP_MIN) ? SAMP_LIM : -in_samp;
  assign square  = samp_r * samp_r;

  // The first element of a tensor always wins; afterwards a strict compare
  // keeps the earliest of equal values.
  assign win = first_r || (mode_is_max(op_mode_r) ? (!alu_rsp.neg && !alu_rsp.zero)
                                                   : alu_rsp.neg);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_xfer) state_nxt = is_norm ? ST_SQUARE : ST_FOLD;
      ST_SQUARE: state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (!last_r) state_nxt = ST_IDLE;
        else         state_nxt = is_norm ? ST_ROOT : ST_EMIT;
      end
      ST_ROOT:   if (bit_r[0]) state_nxt = ST_EMIT;
      ST_EMIT:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and operand selection for the shared unit.
  always_comb begin
    in_ready    = (state_r == ST_IDLE);
    alu_req.a   = running_r;
    alu_req.b   = operand_r;
    alu_req.sub = 1'b0;
    unique case (state_r)
      ST_FOLD: begin
        if (mode_is_cmp(op_mode_r)) begin
          alu_req.a   = operand_r;
          alu_req.b   = running_r;
          alu_req.sub = 1'b1;
        end else if (is_norm && running_r[VAL_W-1]) begin
          // A negative running value left over from another mode counts as zero.
          alu_req.a = '0;
        end
      end
      ST_ROOT: begin
        // res and bit never share set bits, so OR forms their sum.
        alu_req.a   = running_r;
        alu_req.b   = res_r | bit_r;
        alu_req.sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_mode_r   <= MODE_SUM;
      running_r   <= '0;
      best_r      <= '0;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) op_mode_r <= cfg_wr_data;
      // A new result is loaded when the register is free; otherwise the
      // present one stays until its transfer.
      out_valid_r <= (state_r == ST_EMIT && out_free) || (out_valid_r && !out_ready);

      unique case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            samp_r    <= in_samp;
            off_r     <= in_element_offset;
            last_r    <= in_last_element;
            operand_r <= mode_uses_abs(op_mode_r) ? VAL_W'($unsigned(in_abs))
                                                  : VAL_W'(in_samp);
          end
        end
        ST_SQUARE: operand_r <= VAL_W'($unsigned(square));
        ST_FOLD: begin
          if (mode_is_cmp(op_mode_r)) begin
            if (win) begin
              running_r <= operand_r;
              best_r    <= off_r;
            end
          end else begin
            running_r <= alu_rsp.sat;
          end
          first_r <= 1'b0;
          res_r   <= '0;
          bit_r   <= ROOT_START;
        end
        ST_ROOT: begin
          if (!alu_rsp.neg) begin
            running_r <= alu_rsp.sat;
            res_r     <= (res_r >> 1) | bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_reduced_value_r <= is_norm ? res_r : running_r;
            out_winner_offset_r <= mode_is_cmp(op_mode_r) ? best_r : '0;
            running_r           <= '0;
            best_r              <= '0;
            first_r             <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_reduced_value = out_reduced_value_r;
  assign out_winner_offset = out_winner_offset_r;

  // The square-root bit marker walks as a single set bit.
  `TRE_ASSERT_IMPLIES(a_root_onehot, clk, rst_n, state_r == ST_ROOT, $onehot(bit_r))
  // An accepted element goes straight to the square or fold step.
  `TRE_ASSERT_NEXT(a_xfer_to_work, clk, rst_n, in_xfer,
                   state_r == ST_SQUARE || state_r == ST_FOLD)
  // Loading a result presents it and leaves the run state cleared.
  `TRE_ASSERT_NEXT(a_emit_clears, clk, rst_n, state_r == ST_EMIT && out_free,
                   out_valid_r && first_r && state_r == ST_IDLE)

endmodule
`default_nettype wire
